// File: sv/fixed_partition_fit_allocator_macros.svh
// Assertion macros for the fixed partition fit allocator.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_MACROS_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define FPFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define FPFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/fpfa_pkg.sv
// Shared types and constants of the fixed partition fit allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fpfa_pkg;

  localparam int MAX_BLOCKS_DEF  = 16;
  localparam int SIZE_BITS_DEF   = 16;

  localparam int IDX_W           = 4;
  localparam int FIELD_SIZE_W    = 16;
  localparam int CFG_DATA_W      = 5;

  localparam logic CFG_FIT_MODE    = 1'b0;
  localparam logic CFG_BLOCK_COUNT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] BLOCK_COUNT_RST = 5'd16;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DEBIT
  } state_e;

  typedef struct packed {
    logic                    action;
    logic [IDX_W-1:0]        block_index;
    logic [FIELD_SIZE_W-1:0] load_size;
    logic [FIELD_SIZE_W-1:0] request_size;
  } alloc_in_t;

  typedef struct packed {
    logic                    granted;
    logic [IDX_W-1:0]        chosen_block;
    logic [FIELD_SIZE_W-1:0] space_before;
    logic [FIELD_SIZE_W-1:0] space_after;
  } alloc_out_t;

endpackage

`default_nettype wire

// File: sv/fpfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fpfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: sv/fixed_partition_fit_allocator.sv
// Top level of the fixed partition fit allocator: free-space table and scan sequencer.
// Depends on fpfa_pkg, fpfa_ram and fixed_partition_fit_allocator_macros.svh.
//
// Usage:
//   Input: a transaction is taken at a rising edge with start_i high and busy_o low.
//   A load transaction writes one block's free space in that edge and returns
//   no result; busy_o stays low, so loads may follow every cycle.
//   An allocate transaction raises busy_o and scans blocks 0 .. limit-1 one per
//   cycle through the single read port of the free-space RAM, where limit is
//   block_count clamped to MAX_BLOCKS. One comparator pair tracks the best
//   block; first fit stops at the first hit. A debit cycle writes back the
//   chosen block and registers the result.
//   done_o rises once the scan and the debit cycle are through, sooner when first
//   fit hits early; when limit is zero the sequencer goes from idle straight to
//   the debit state. A new transaction is taken in the cycle of done_o.
//   Output: done_o marks out_o for exactly one cycle; the receiver cannot stall.
//   Configuration: cfg_we_i writes fit_mode or block_count; write only when idle.
//   Reset: fit_mode clears to first fit, block_count to 16; the table contents
//   are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

`include "fixed_partition_fit_allocator_macros.svh"

module fixed_partition_fit_allocator #(
  parameter int MAX_BLOCKS = fpfa_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpfa_pkg::SIZE_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic                                cfg_idx_i,
  input  wire logic [fpfa_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                                start_i,
  input  wire fpfa_pkg::alloc_in_t                 in_i,
  output      logic                                busy_o,
  output      logic                                done_o,
  output      fpfa_pkg::alloc_out_t                out_o
);

  import fpfa_pkg::*;

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  state_e                  state_q, state_d;
  logic [1:0]              fit_mode_q;
  logic [CFG_DATA_W-1:0]   block_count_q;
  logic [CW-1:0]           limit_q, limit_d;
  logic [CW-1:0]           addr_q, addr_d;
  logic                    cmp_v_q, cmp_v_d;
  logic [IW-1:0]           cmp_idx_q, cmp_idx_d;
  logic                    found_q, found_d;
  logic [IW-1:0]           pick_q, pick_d;
  logic [SIZE_BITS-1:0]    best_q, best_d;
  logic [SIZE_BITS-1:0]    req_q, req_d;
  logic                    done_q, done_d;
  alloc_out_t              out_q, out_d;

  logic                    accept;
  logic                    issue;
  logic                    is_best, is_worst;
  logic                    fits, take, last;
  logic [SIZE_BITS-1:0]    rd_data;
  logic [SIZE_BITS-1:0]    diff;
  logic [CW-1:0]           count_clamped;
  logic                    ram_we;
  logic [IW-1:0]           ram_waddr;
  logic [SIZE_BITS-1:0]    ram_wdata;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign is_best  = (fit_mode_q == FIT_BEST);
  assign is_worst = (fit_mode_q == FIT_WORST);
  assign issue    = (state_q == ST_SCAN) && (addr_q < limit_q);
  assign diff     = best_q - req_q;

  assign count_clamped = (32'(block_count_q) > MAX_BLOCKS) ? CW'(MAX_BLOCKS)
                                                           : CW'(block_count_q);

  assign fits = (rd_data >= req_q);
  assign take = fits && (!found_q || (is_best && (rd_data < best_q))
                                  || (is_worst && (rd_data > best_q)));
  assign last = ((CW'(cmp_idx_q) + CW'(1)) == limit_q);

  fpfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_BLOCKS)
  ) u_space_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (issue),
    .raddr_i (addr_q[IW-1:0]),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d   = state_q;
    limit_d   = limit_q;
    addr_d    = addr_q;
    cmp_v_d   = issue;
    cmp_idx_d = addr_q[IW-1:0];
    found_d   = found_q;
    pick_d    = pick_q;
    best_d    = best_q;
    req_d     = req_q;
    done_d    = 1'b0;
    out_d     = out_q;
    ram_we    = 1'b0;
    ram_waddr = pick_q;
    ram_wdata = diff;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.action == ACT_LOAD) begin
            ram_we    = (32'(in_i.block_index) < MAX_BLOCKS);
            ram_waddr = IW'(in_i.block_index);
            ram_wdata = SIZE_BITS'(in_i.load_size);
          end else begin
            req_d   = SIZE_BITS'(in_i.request_size);
            limit_d = count_clamped;
            addr_d  = '0;
            found_d = 1'b0;
            state_d = (count_clamped == '0) ? ST_DEBIT : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          addr_d = addr_q + CW'(1);
        end
        if (cmp_v_q) begin
          if (take) begin
            found_d = 1'b1;
            pick_d  = cmp_idx_q;
            best_d  = rd_data;
          end
          if ((fits && !is_best && !is_worst) || last) begin
            state_d = ST_DEBIT;
          end
        end
      end
      ST_DEBIT: begin
        ram_we = found_q;
        done_d = 1'b1;
        out_d.granted      = found_q;
        out_d.chosen_block = found_q ? IDX_W'(pick_q) : '0;
        out_d.space_before = found_q ? FIELD_SIZE_W'(best_q) : '0;
        out_d.space_after  = found_q ? FIELD_SIZE_W'(diff) : '0;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      fit_mode_q    <= FIT_FIRST;
      block_count_q <= BLOCK_COUNT_RST;
      cmp_v_q       <= 1'b0;
      found_q       <= 1'b0;
      done_q        <= 1'b0;
      limit_q       <= '0;
      addr_q        <= '0;
    end else begin
      state_q <= state_d;
      cmp_v_q <= cmp_v_d;
      found_q <= found_d;
      done_q  <= done_d;
      limit_q <= limit_d;
      addr_q  <= addr_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FIT_MODE:    fit_mode_q    <= cfg_data_i[1:0];
          CFG_BLOCK_COUNT: block_count_q <= cfg_data_i;
          default:         fit_mode_q    <= fit_mode_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    pick_q    <= pick_d;
    best_q    <= best_d;
    req_q     <= req_d;
    out_q     <= out_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign out_o  = out_q;

  `FPFA_ASSERT_NEXT(a_debit_strobes, state_q == ST_DEBIT, done_q && (state_q == ST_IDLE), "debit cycle must end in one result strobe")
  `FPFA_ASSERT_NOW(a_pick_in_range, (state_q == ST_DEBIT) && found_q, CW'(pick_q) < limit_q, "chosen block outside scanned range")
  `FPFA_ASSERT_NOW(a_no_write_in_scan, state_q == ST_SCAN, !ram_we, "table written during scan")
  `FPFA_ASSERT_NEXT(a_alloc_goes_busy, accept && (in_i.action == ACT_ALLOC), busy_o, "allocate transaction did not start sequencer")

endmodule

`default_nettype wire
